/* design/lpst_pkg.sv */
`default_nettype none

package lpst_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    localparam int PORT_W = 16;
    localparam int LIMIT_W = 8;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(TABLE_DEPTH);

    localparam logic [LIMIT_W-1:0] READ_LIMIT_RST = 8'd128;
    localparam logic [LIMIT_W-1:0] COUNT_LIMIT_RST = 8'd128;

    typedef enum logic [0:0] {
        REG_READ_LIMIT  = 1'b0,
        REG_COUNT_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_DUP      = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_FILTERED = 3'd4,
        STAT_RANGE    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/local_port_set_table.sv */
// Insertion-ordered set of local TCP ports.
//
// Input channel s_*: one request per transfer (add, remove or read).
// Result channel m_*: exactly one result per request, in request order.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write read_limit (0) and
// count_limit (1); write only while no request is in flight.
//
// A read fetches its entry in S_READ and takes the data in S_READ_WAIT;
// an add or remove searches from entry 0, and a remove that matches then
// compacts the entries above the match; filtered and out-of-range
// requests go straight to S_DONE.
// The entries sit in a single-port-read RAM with registered read data; the
// search and the compaction walk it one entry per cycle, and the search
// compares through one comparator. s_tready is high only between requests.
//
// Reset empties the table and restores both limits to 128; the RAM itself
// is not cleared. A stalled result waits in the output register; the next
// request then holds in its last state until that result is taken.
`default_nettype none

module local_port_set_table (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // [1:0] op, [9:2] protocol, [41:10] local_addr, [57:42] port_number,
    // [64:58] read_index, [71:65] zero
    input  wire logic [lpst_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [2:0] status, [18:3] port_value, [26:19] entry_count, [27] count_ok,
    // [31:28] zero
    output logic [lpst_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_index,
    input  wire logic [lpst_pkg::LIMIT_W-1:0]     cfg_wdata
);

    localparam int IDX_W = lpst_pkg::IDX_W;
    localparam int CNT_W = lpst_pkg::CNT_W;
    localparam int CMP_W = lpst_pkg::CMP_W;
    localparam int PORT_W = lpst_pkg::PORT_W;

    // input fields
    lpst_pkg::op_t     in_op;
    logic [7:0]        in_protocol;
    logic [31:0]       in_addr;
    logic [PORT_W-1:0] in_port;
    logic [6:0]        in_index;

    assign in_op       = lpst_pkg::op_t'(s_tdata[1:0]);
    assign in_protocol = s_tdata[9:2];
    assign in_addr     = s_tdata[41:10];
    assign in_port     = s_tdata[57:42];
    assign in_index    = s_tdata[64:58];

    lpst_pkg::state_t  state_reg, state_next;
    lpst_pkg::op_t     op_reg, op_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              chk_reg, chk_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    lpst_pkg::status_t res_status_reg, res_status_next;
    logic [PORT_W-1:0] res_value_reg, res_value_next;
    logic [lpst_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [lpst_pkg::LIMIT_W-1:0] read_limit_reg, read_limit_next;
    logic [lpst_pkg::LIMIT_W-1:0] count_limit_reg, count_limit_next;

    // entry RAM
    logic [PORT_W-1:0] mem [lpst_pkg::TABLE_DEPTH];
    logic [PORT_W-1:0] rdata_reg;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [PORT_W-1:0] mem_wdata;

    logic accept;
    logic qualified;
    logic in_range;
    logic match;
    logic ptr_end;
    logic out_free;
    logic [CNT_W-1:0] shift_dst;
    logic [CMP_W-1:0] idx_ext;
    logic count_ok;

    assign s_tready = (state_reg == lpst_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign qualified = (in_protocol == lpst_pkg::PROTO_TCP)
                    && (in_addr != lpst_pkg::LOOPBACK_ADDR)
                    && (in_port != '0);
    assign idx_ext   = CMP_W'(in_index);
    assign in_range  = (idx_ext < CMP_W'(read_limit_reg))
                    && (idx_ext < CMP_W'(count_reg))
                    && (idx_ext < lpst_pkg::DEPTH_CMP);

    // rdata_reg holds entry ptr_reg-1 whenever chk_reg is set
    assign match     = chk_reg && (rdata_reg == port_reg);
    assign ptr_end   = (ptr_reg >= count_reg);
    assign shift_dst = CNT_W'(ptr_reg - CNT_W'(2));
    assign count_ok  = (CMP_W'(count_reg) <= CMP_W'(count_limit_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpst_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        lpst_pkg::OP_ADD,
                        lpst_pkg::OP_REMOVE: begin
                            state_next = qualified ? lpst_pkg::S_SEARCH : lpst_pkg::S_DONE;
                        end
                        lpst_pkg::OP_READ: begin
                            state_next = in_range ? lpst_pkg::S_READ : lpst_pkg::S_DONE;
                        end
                        default: begin
                            state_next = lpst_pkg::S_DONE;
                        end
                    endcase
                end
            end
            lpst_pkg::S_SEARCH: begin
                if (match) begin
                    state_next = (op_reg == lpst_pkg::OP_REMOVE) ? lpst_pkg::S_SHIFT
                                                                 : lpst_pkg::S_DONE;
                end else if (ptr_end) begin
                    state_next = lpst_pkg::S_DONE;
                end
            end
            lpst_pkg::S_SHIFT: begin
                if (!chk_reg && ptr_end) begin
                    state_next = lpst_pkg::S_DONE;
                end
            end
            lpst_pkg::S_READ: begin
                state_next = lpst_pkg::S_READ_WAIT;
            end
            lpst_pkg::S_READ_WAIT: begin
                state_next = lpst_pkg::S_DONE;
            end
            lpst_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = lpst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lpst_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next          = op_reg;
        port_next        = port_reg;
        ptr_next         = ptr_reg;
        chk_next         = chk_reg;
        count_next       = count_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        read_limit_next  = read_limit_reg;
        count_limit_next = count_limit_reg;
        mem_re           = 1'b0;
        mem_raddr        = ptr_reg[IDX_W-1:0];
        mem_we           = 1'b0;
        mem_waddr        = shift_dst[IDX_W-1:0];
        mem_wdata        = rdata_reg;

        if (cfg_wr_en) begin
            case (lpst_pkg::cfg_reg_t'(cfg_index))
                lpst_pkg::REG_READ_LIMIT:  read_limit_next  = cfg_wdata;
                lpst_pkg::REG_COUNT_LIMIT: count_limit_next = cfg_wdata;
                default: begin
                end
            endcase
        end

        case (state_reg)
            lpst_pkg::S_IDLE: begin
                if (accept) begin
                    op_next         = in_op;
                    port_next       = in_port;
                    ptr_next        = '0;
                    chk_next        = 1'b0;
                    res_value_next  = '0;
                    res_status_next = lpst_pkg::STAT_OK;
                    case (in_op)
                        lpst_pkg::OP_ADD,
                        lpst_pkg::OP_REMOVE: begin
                            if (!qualified) begin
                                res_status_next = lpst_pkg::STAT_FILTERED;
                            end
                        end
                        lpst_pkg::OP_READ: begin
                            if (in_range) begin
                                ptr_next = CNT_W'(in_index);
                            end else begin
                                res_status_next = lpst_pkg::STAT_RANGE;
                            end
                        end
                        default: begin
                            res_status_next = lpst_pkg::STAT_FILTERED;
                        end
                    endcase
                end
            end
            lpst_pkg::S_SEARCH: begin
                if (match) begin
                    chk_next = 1'b0;
                    if (op_reg != lpst_pkg::OP_REMOVE) begin
                        res_status_next = lpst_pkg::STAT_DUP;
                    end
                end else if (ptr_end) begin
                    chk_next = 1'b0;
                    if (op_reg == lpst_pkg::OP_REMOVE) begin
                        res_status_next = lpst_pkg::STAT_NOTFOUND;
                    end else if (count_reg == lpst_pkg::FULL_COUNT) begin
                        res_status_next = lpst_pkg::STAT_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = port_reg;
                        count_next = CNT_W'(count_reg + CNT_W'(1));
                    end
                end else begin
                    mem_re   = 1'b1;
                    ptr_next = CNT_W'(ptr_reg + CNT_W'(1));
                    chk_next = 1'b1;
                end
            end
            lpst_pkg::S_SHIFT: begin
                // move entry ptr-1 down to ptr-2 while fetching entry ptr
                if (chk_reg) begin
                    mem_we = 1'b1;
                end
                if (!ptr_end) begin
                    mem_re   = 1'b1;
                    ptr_next = CNT_W'(ptr_reg + CNT_W'(1));
                    chk_next = 1'b1;
                end else begin
                    chk_next = 1'b0;
                    if (!chk_reg) begin
                        count_next = CNT_W'(count_reg - CNT_W'(1));
                    end
                end
            end
            lpst_pkg::S_READ: begin
                mem_re = 1'b1;
            end
            lpst_pkg::S_READ_WAIT: begin
                res_value_next = rdata_reg;
            end
            lpst_pkg::S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, count_ok, 8'(count_reg),
                                     res_value_reg, res_status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lpst_pkg::S_IDLE;
            chk_reg         <= 1'b0;
            count_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
            read_limit_reg  <= lpst_pkg::READ_LIMIT_RST;
            count_limit_reg <= lpst_pkg::COUNT_LIMIT_RST;
        end else begin
            state_reg       <= state_next;
            chk_reg         <= chk_next;
            count_reg       <= count_next;
            m_tvalid_reg    <= m_tvalid_next;
            read_limit_reg  <= read_limit_next;
            count_limit_reg <= count_limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        port_reg       <= port_next;
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lpst_pkg::FULL_COUNT)
        else $error("entry count above table depth");

    a_shift_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lpst_pkg::S_SHIFT |=> count_reg <= $past(count_reg))
        else $error("compaction grew the table");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request taken while another is in flight");

    a_chk_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_reg |-> ptr_reg != '0)
        else $error("pending compare without a fetched entry");

endmodule

`default_nettype wire

/* bench/tb_local_port_set_table.sv */
`default_nettype none

module tb_local_port_set_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    // quiet margin before the limits are rewritten
    localparam int SETTLE_CYCLES = 2 * lpst_pkg::TABLE_DEPTH + 16;
    localparam int NUM_PHASES = 5;

    typedef struct {
        lpst_pkg::status_t status;
        logic [15:0]       port_value;
        logic [7:0]        entry_count;
        logic              count_ok;
    } table_result_t;

    class port_set_tracker;
        logic [15:0]   stored_ports[$];
        logic [7:0]    read_limit = lpst_pkg::READ_LIMIT_RST;
        logic [7:0]    count_limit = lpst_pkg::COUNT_LIMIT_RST;
        table_result_t expected_results[$];
        int            errors = 0;

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int entry_count();
            return stored_ports.size();
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function logic [15:0] pick_stored();
            return stored_ports[$urandom_range(0, stored_ports.size() - 1)];
        endfunction

        function int find_port(logic [15:0] port);
            foreach (stored_ports[i])
                if (stored_ports[i] == port)
                    return i;
            return -1;
        endfunction

        function void note_request(lpst_pkg::op_t op, logic [7:0] proto, logic [31:0] addr,
                                   logic [15:0] port, logic [6:0] idx);
            table_result_t r;
            bit            qualified;
            int            pos;
            r.status = lpst_pkg::STAT_OK;
            r.port_value = '0;
            qualified = (proto == lpst_pkg::PROTO_TCP) && (addr != lpst_pkg::LOOPBACK_ADDR)
                        && (port != 0);
            case (op)
                lpst_pkg::OP_ADD: begin
                    if (!qualified)
                        r.status = lpst_pkg::STAT_FILTERED;
                    else if (find_port(port) >= 0)
                        r.status = lpst_pkg::STAT_DUP;     // duplicate wins over full
                    else if (stored_ports.size() >= lpst_pkg::TABLE_DEPTH)
                        r.status = lpst_pkg::STAT_FULL;
                    else
                        stored_ports.push_back(port);
                end
                lpst_pkg::OP_REMOVE: begin
                    if (!qualified) begin
                        r.status = lpst_pkg::STAT_FILTERED;
                    end else begin
                        pos = find_port(port);
                        if (pos < 0)
                            r.status = lpst_pkg::STAT_NOTFOUND;
                        else
                            stored_ports.delete(pos);
                    end
                end
                lpst_pkg::OP_READ: begin
                    // reads ignore protocol, address and port
                    if (int'(idx) < int'(read_limit) && int'(idx) < stored_ports.size())
                        r.port_value = stored_ports[idx];
                    else
                        r.status = lpst_pkg::STAT_RANGE;
                end
                default: r.status = lpst_pkg::STAT_FILTERED;
            endcase
            r.entry_count = 8'(stored_ports.size());
            r.count_ok = (stored_ports.size() <= int'(count_limit));
            expected_results.push_back(r);
        endfunction

        task check_result(logic [lpst_pkg::M_TDATA_W-1:0] word);
            table_result_t r;
            if (expected_results.size() == 0) begin
                report($sformatf("result 0x%08h with nothing pending", word));
            end else begin
                r = expected_results.pop_front();
                if (word[2:0] !== r.status)
                    report($sformatf("status got %0d exp %0d", word[2:0], r.status));
                if (word[18:3] !== r.port_value)
                    report($sformatf("port_value got %0d exp %0d", word[18:3], r.port_value));
                if (word[26:19] !== r.entry_count)
                    report($sformatf("entry_count got %0d exp %0d", word[26:19],
                                     r.entry_count));
                if (word[27] !== r.count_ok)
                    report($sformatf("count_ok got %0b exp %0b", word[27], r.count_ok));
            end
        endtask
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic [lpst_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lpst_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic                             cfg_index = 1'b0;
    logic [lpst_pkg::LIMIT_W-1:0]     cfg_wdata = '0;

    port_set_tracker tracker = new;
    int              cycle_count = 0;
    bit              tx_burst = 1'b0;
    bit              rx_burst = 1'b0;

    int         phase_items[NUM_PHASES] = '{400, 150, 300, 250, 250};
    int         phase_add[NUM_PHASES] = '{80, 30, 15, 40, 70};
    int         phase_remove[NUM_PHASES] = '{5, 20, 45, 25, 10};
    int         phase_read[NUM_PHASES] = '{10, 35, 30, 25, 15};
    logic [7:0] phase_rd_lim[NUM_PHASES] = '{8'd128, 8'd0, 8'd255, 8'd0, 8'd128};
    logic [7:0] phase_cnt_lim[NUM_PHASES] = '{8'd128, 8'd0, 8'd64, 8'd0, 8'd127};

    local_port_set_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_local_port_set_table: done, errors");
        $finish;
    end

    // result side: random stalls, with stretches of always-ready
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_result(m_tdata);
        end
    end

    // valid stays high across back-to-back transfers; only a gap lowers it
    task automatic send_request(lpst_pkg::op_t op, logic [7:0] proto, logic [31:0] addr,
                                logic [15:0] port, logic [6:0] idx);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {7'd0, idx, port, addr, proto, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_request(op, proto, addr, port, idx);
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_limits(logic [7:0] rd_lim, logic [7:0] cnt_lim);
        cfg_index <= lpst_pkg::REG_READ_LIMIT;
        cfg_wdata <= rd_lim;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        tracker.read_limit = rd_lim;
        cfg_index <= lpst_pkg::REG_COUNT_LIMIT;
        cfg_wdata <= cnt_lim;
        @(posedge aclk);
        tracker.count_limit = cnt_lim;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_request(int add_pct, int remove_pct, int read_pct);
        int            roll;
        int            pick;
        int            n;
        lpst_pkg::op_t op;
        logic [7:0]    proto;
        logic [31:0]   addr;
        logic [15:0]   port;
        logic [6:0]    idx;
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        n = tracker.entry_count();
        op = lpst_pkg::OP_ADD;
        proto = lpst_pkg::PROTO_TCP;
        addr = $urandom;
        port = 16'($urandom_range(1, 1023));
        idx = 7'($urandom_range(0, 127));
        if (roll < add_pct) begin
            if (pick < 15 && n > 0)
                port = tracker.pick_stored();
            else if (pick < 30)
                port = 16'($urandom_range(1, 65535));
        end else if (roll < add_pct + remove_pct) begin
            op = lpst_pkg::OP_REMOVE;
            if (pick < 70 && n > 0)
                port = tracker.pick_stored();
            else if (pick < 80)
                port = 16'($urandom_range(1, 65535));
        end else if (roll < add_pct + remove_pct + read_pct) begin
            op = lpst_pkg::OP_READ;
            if (pick < 80 && n > 0)
                idx = 7'($urandom_range(0, n - 1));
            proto = 8'($urandom);
            port = 16'($urandom);
        end else begin
            // noise: unqualified items under a random opcode, including the unused one
            op = lpst_pkg::op_t'(2'($urandom_range(0, 3)));
            case (pick % 4)
                0: proto = 8'($urandom);
                1: addr = lpst_pkg::LOOPBACK_ADDR;
                2: port = '0;
                default: begin
                    proto = 8'($urandom);
                    port = 16'($urandom);
                end
            endcase
        end
        send_request(op, proto, addr, port, idx);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: filters, extremes, duplicate, compaction, range checks
        send_request(lpst_pkg::OP_READ, lpst_pkg::PROTO_TCP, 32'd1, 16'd80, 7'd0);
        send_request(lpst_pkg::OP_ADD, 8'd17, 32'h0A00_0001, 16'd80, 7'd0);
        send_request(lpst_pkg::OP_ADD, lpst_pkg::PROTO_TCP, lpst_pkg::LOOPBACK_ADDR,
                     16'd80, 7'd0);
        send_request(lpst_pkg::OP_ADD, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'd0, 7'd0);
        send_request(lpst_pkg::OP_NONE, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'd80, 7'd0);
        send_request(lpst_pkg::OP_REMOVE, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'd5, 7'd0);
        send_request(lpst_pkg::OP_ADD, lpst_pkg::PROTO_TCP, 32'h0000_0000, 16'hFFFF, 7'd0);
        send_request(lpst_pkg::OP_ADD, lpst_pkg::PROTO_TCP, 32'hFFFF_FFFF, 16'd1, 7'd127);
        send_request(lpst_pkg::OP_ADD, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'd1, 7'd0);
        send_request(lpst_pkg::OP_ADD, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'd443, 7'd0);
        send_request(lpst_pkg::OP_READ, 8'd0, 32'd0, 16'd0, 7'd0);
        send_request(lpst_pkg::OP_READ, 8'hFF, lpst_pkg::LOOPBACK_ADDR, 16'hFFFF, 7'd2);
        send_request(lpst_pkg::OP_READ, lpst_pkg::PROTO_TCP, 32'd1, 16'd1, 7'd3);
        send_request(lpst_pkg::OP_READ, lpst_pkg::PROTO_TCP, 32'd1, 16'd1, 7'd127);
        send_request(lpst_pkg::OP_REMOVE, lpst_pkg::PROTO_TCP, lpst_pkg::LOOPBACK_ADDR,
                     16'hFFFF, 7'd0);
        send_request(lpst_pkg::OP_REMOVE, 8'd0, 32'h0A00_0001, 16'hFFFF, 7'd0);
        send_request(lpst_pkg::OP_REMOVE, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'hFFFF, 7'd0);
        send_request(lpst_pkg::OP_READ, lpst_pkg::PROTO_TCP, 32'd1, 16'd1, 7'd0);
        send_request(lpst_pkg::OP_READ, lpst_pkg::PROTO_TCP, 32'd1, 16'd1, 7'd1);
        send_request(lpst_pkg::OP_REMOVE, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'd443, 7'd0);
        send_request(lpst_pkg::OP_REMOVE, lpst_pkg::PROTO_TCP, 32'h0A00_0001, 16'd443, 7'd0);
        send_request(lpst_pkg::OP_REMOVE, 8'hFF, 32'h0A00_0001, 16'd1, 7'd0);
        send_request(lpst_pkg::OP_NONE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 7'h7F);
        send_request(lpst_pkg::OP_ADD, 8'hFF, 32'h0A00_0001, 16'd22, 7'd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_idle();
            if (p == 3)
                program_limits(8'($urandom_range(1, 127)), 8'($urandom_range(1, 127)));
            else
                program_limits(phase_rd_lim[p], phase_cnt_lim[p]);
            for (int i = 0; i < phase_items[p]; i++)
                random_request(phase_add[p], phase_remove[p], phase_read[p]);
        end

        settle_idle();
        if (tracker.errors == 0)
            $display("tb_local_port_set_table: done, clean");
        else
            $display("tb_local_port_set_table: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
